[design/icc_pkg.sv]
// Package for the interrupt claim/complete controller: opcode codes,
// register offsets, field widths and stream word layouts.
// No dependencies.
`timescale 1ns / 1ps

package icc_pkg;

  // Item kinds carried on tuser
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LINE  = 2'd2
  } opcode_e;

  localparam int unsigned NUM_SOURCES_DEF = 32;
  localparam int unsigned MAX_SOURCES     = 32;

  // Field widths
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned OFFSET_W = 26;
  localparam int unsigned SIZE_W   = 4;
  localparam int unsigned WDATA_W  = 32;
  localparam int unsigned SRC_W    = 6;
  localparam int unsigned RDATA_W  = 6;

  localparam logic [OFFSET_W-1:0] CLAIM_OFFSET = 26'h0200004;
  localparam logic [SIZE_W-1:0]   WORD_SIZE    = 4'd4;

  // Input word: offset, size, write data, source, level, padded to bytes
  localparam int unsigned IN_BITS   = OFFSET_W + SIZE_W + WDATA_W + SRC_W + 1;
  localparam int unsigned IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned IN_USER_W = OPCODE_W;

  // Output word: read data, error, external interrupt
  localparam int unsigned OUT_BITS   = RDATA_W + 2;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic                external_irq;
    logic                access_error;
    logic [RDATA_W-1:0]  read_data;
  } result_t;

  typedef struct packed {
    logic                line_level;
    logic [SRC_W-1:0]    source_number;
    logic [WDATA_W-1:0]  write_data;
    logic [SIZE_W-1:0]   access_size;
    logic [OFFSET_W-1:0] access_offset;
  } item_t;

endpackage

[design/interrupt_claim_complete_controller_core.sv]
// Interrupt claim/complete controller core: pending and served masks,
// claim read with lowest-source priority encoder, completion write.
// Depends on icc_pkg.
`timescale 1ns / 1ps

// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: item_t, tuser: opcode
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: result_t
//
// One word per cycle sustained while the output is taken; each word passes
// through the input register and its result leaves from the output register.
// The state update and the priority encode sit between those two registers.
// Reset clears both masks and both valid flags.
// A stalled output holds the result; the input register still drains into
// it once it is taken, so s_axis_tready only drops while both are full.

module interrupt_claim_complete_controller_core #(
  parameter int unsigned NUM_SOURCES = icc_pkg::NUM_SOURCES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [25:0] access_offset, [29:26] access_size, [61:30] write_data,
  // [67:62] source_number, [68] line_level, [71:69] unused
  input  logic [icc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] opcode
  input  logic [icc_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [5:0] read_data, [6] access_error, [7] external_irq
  output logic [icc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import icc_pkg::*;

  // Input register
  logic                 in_valid_q;
  item_t                item_q;
  logic [OPCODE_W-1:0]  opcode_q;

  // State
  logic [NUM_SOURCES-1:0] pending_q, pending_d;
  logic [NUM_SOURCES-1:0] served_q, served_d;

  // Output register
  logic    out_valid_q;
  result_t result_q, result_d;

  logic advance;
  logic in_load;

  logic [NUM_SOURCES-1:0] open_req;
  logic [NUM_SOURCES-1:0] claim_oh;
  logic [RDATA_W-1:0]     claim_num;
  logic [NUM_SOURCES-1:0] src_oh;
  logic [NUM_SOURCES-1:0] done_oh;
  logic                   size_ok;
  logic                   at_claim;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      item_q   <= item_t'(s_axis_tdata[IN_BITS-1:0]);
      opcode_q <= s_axis_tuser;
    end
  end

  // Lowest open request; isolate it with x & -x, then encode
  assign open_req = pending_q & ~served_q;
  assign claim_oh = open_req & (~open_req + NUM_SOURCES'(1));

  always_comb begin
    claim_num = '0;
    for (int i = 0; i < NUM_SOURCES; i++) begin
      if (claim_oh[i]) claim_num = claim_num | RDATA_W'(i + 1);
    end
  end

  // Source and completion decoders, numbered from 1; out of range gives 0
  always_comb begin
    for (int i = 0; i < NUM_SOURCES; i++) begin
      src_oh[i]  = (item_q.source_number == SRC_W'(i + 1));
      done_oh[i] = (item_q.write_data == WDATA_W'(i + 1));
    end
  end

  assign size_ok  = (item_q.access_size == WORD_SIZE);
  assign at_claim = (item_q.access_offset == CLAIM_OFFSET);

  always_comb begin
    pending_d = pending_q;
    served_d  = served_q;
    result_d  = '0;
    case (opcode_e'(opcode_q))
      OP_LINE: begin
        if (item_q.line_level) pending_d = pending_q | src_oh;
        else                   pending_d = pending_q & ~src_oh;
      end
      OP_READ: begin
        if (!size_ok) begin
          result_d.access_error = 1'b1;
        end else if (at_claim) begin
          served_d           = served_q | claim_oh;
          result_d.read_data = claim_num;
        end
      end
      OP_WRITE: begin
        if (!size_ok) begin
          result_d.access_error = 1'b1;
        end else if (at_claim) begin
          served_d = served_q & ~done_oh;
        end
      end
      default: ;
    endcase
    result_d.external_irq = |(pending_d & ~served_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= '0;
      served_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        pending_q <= pending_d;
        served_q  <= served_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) result_q <= result_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'(result_q);

`ifndef SYNTHESIS
  // A claim marks at most one source served per word
  a_one_claim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(served_q & ~$past(served_q)) <= 1)
    else $error("more than one source claimed in one cycle");

  // An erroneous access never returns a source number
  a_err_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && result_q.access_error) |-> (result_q.read_data == '0))
    else $error("error result carries read data");

  // The interrupt flag of a result matches the state it left behind
  a_irq_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (result_q.external_irq == |(pending_q & ~served_q)))
    else $error("external_irq does not match updated masks");
`endif

endmodule

[tb/icc_claim_checker.sv]
// Scoreboard for the interrupt claim/complete controller: follows both stream
// channels, keeps its own pending/served masks and checks every result word.
// Depends on icc_pkg.
`timescale 1ns / 1ps

module icc_claim_checker
  import icc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,
  input  logic [IN_USER_W-1:0]   s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                   end_of_run_i,
  output int                     error_count_o,
  output int                     outstanding_o,
  output int                     results_checked_o,
  output int                     claims_granted_o
);

  localparam int unsigned SOURCES = NUM_SOURCES_DEF;

  logic [MAX_SOURCES-1:0] pending_mask;
  logic [MAX_SOURCES-1:0] served_mask;
  result_t                expected_results[$];
  bit                     leftovers_checked;

  initial begin
    error_count_o     = 0;
    outstanding_o     = 0;
    results_checked_o = 0;
    claims_granted_o  = 0;
    leftovers_checked = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    error_count_o++;
  endtask

  // Applies one input word to the local masks and returns its result word.
  function automatic result_t claim_result(input logic [1:0] op, input item_t it);
    result_t                res;
    logic [MAX_SOURCES-1:0] open_req;
    logic [WDATA_W-1:0]     done_idx;
    int                     first;
    res   = '0;
    first = 0;
    case (op)
      OP_LINE: begin
        if (it.source_number >= 1 && it.source_number <= SOURCES) begin
          pending_mask[it.source_number - 1] = it.line_level;
        end
      end
      OP_READ, OP_WRITE: begin
        if (it.access_size != WORD_SIZE) begin
          res.access_error = 1'b1;
        end else if (it.access_offset == CLAIM_OFFSET) begin
          if (op == OP_READ) begin
            open_req = pending_mask & ~served_mask;
            for (int i = MAX_SOURCES - 1; i >= 0; i--) begin
              if (open_req[i]) first = i;
            end
            if (open_req != '0) begin
              served_mask[first] = 1'b1;
              res.read_data      = RDATA_W'(first + 1);
            end
          end else begin
            // completion index wraps for zero, so zero lands out of range
            done_idx = it.write_data - 32'd1;
            if (done_idx < SOURCES) served_mask[done_idx[4:0]] = 1'b0;
          end
        end
      end
      default: ;
    endcase
    res.external_irq = |(pending_mask & ~served_mask);
    return res;
  endfunction

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      pending_mask = '0;
      served_mask  = '0;
      expected_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[OUT_BITS-1:0]);
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result word %h", m_axis_tdata));
        end else begin
          want = expected_results.pop_front();
          results_checked_o++;
          if (got.read_data != want.read_data)
            report_mismatch($sformatf("read_data %0d, expected %0d",
                                      got.read_data, want.read_data));
          if (got.access_error != want.access_error)
            report_mismatch($sformatf("access_error %b, expected %b",
                                      got.access_error, want.access_error));
          if (got.external_irq != want.external_irq)
            report_mismatch($sformatf("external_irq %b, expected %b",
                                      got.external_irq, want.external_irq));
          if (want.read_data != '0) claims_granted_o++;
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(claim_result(s_axis_tuser,
                                                item_t'(s_axis_tdata[IN_BITS-1:0])));
      if (end_of_run_i && !leftovers_checked) begin
        leftovers_checked = 1;
        if (expected_results.size() != 0)
          report_mismatch($sformatf("%0d result words never arrived",
                                    expected_results.size()));
      end
    end
    outstanding_o = expected_results.size();
  end

endmodule

[tb/tb.sv]
// Top of the controller testbench: clock, reset, directed and random stream
// stimulus, random output stalls and the final verdict.
// Depends on icc_pkg, the controller core and icc_claim_checker.
`timescale 1ns / 1ps

module tb;
  import icc_pkg::*;

  localparam logic [1:0]          OP_RESERVED  = 2'd3;
  localparam logic [OFFSET_W-1:0] ENABLE_OFFSET = 26'h0200000;
  localparam int                  RANDOM_WORDS = 550;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  end_of_run = 1'b0;
  bit                    calm = 0;  // no idling on either side while set
  int                    error_count;
  int                    outstanding;
  int                    results_checked;
  int                    claims_granted;
  int                    words_sent = 0;

  always #5 clk_i = ~clk_i;

  interrupt_claim_complete_controller_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  icc_claim_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .s_axis_tdata      (s_axis_tdata),
    .s_axis_tuser      (s_axis_tuser),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tdata      (m_axis_tdata),
    .end_of_run_i      (end_of_run),
    .error_count_o     (error_count),
    .outstanding_o     (outstanding),
    .results_checked_o (results_checked),
    .claims_granted_o  (claims_granted)
  );

  // Sink side: random back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 14);
  end

  function automatic item_t make_item(input logic [OFFSET_W-1:0] offset,
                                      input logic [SIZE_W-1:0] size,
                                      input logic [WDATA_W-1:0] wdata,
                                      input logic [SRC_W-1:0] src,
                                      input logic level);
    item_t it;
    it.access_offset = offset;
    it.access_size   = size;
    it.write_data    = wdata;
    it.source_number = src;
    it.line_level    = level;
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input logic [1:0] op, input item_t it);
    while (!calm && $urandom_range(0, 99) < 14) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'(it);
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic claim_read(input logic [SIZE_W-1:0] size);
    send_word(OP_READ, make_item(CLAIM_OFFSET, size, $urandom, SRC_W'($urandom),
                                 1'($urandom)));
  endtask

  task automatic claim_write(input logic [WDATA_W-1:0] wdata, input logic [SIZE_W-1:0] size);
    send_word(OP_WRITE, make_item(CLAIM_OFFSET, size, wdata, SRC_W'($urandom),
                                  1'($urandom)));
  endtask

  task automatic line_event(input logic [SRC_W-1:0] src, input logic level);
    send_word(OP_LINE, make_item(OFFSET_W'($urandom), SIZE_W'($urandom), $urandom,
                                 src, level));
  endtask

  initial begin
    logic [1:0] op;
    item_t      it;
    int         pick;
    int         drain_cycles;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty claim, out-of-range sources and completions,
    // wrong sizes, other offsets, unused opcode, completion and re-claim.
    claim_read(WORD_SIZE);
    line_event(6'd1, 1'b1);
    line_event(6'd32, 1'b1);
    line_event(6'd0, 1'b1);
    line_event(6'd33, 1'b1);
    line_event(6'd63, 1'b1);
    claim_read(WORD_SIZE);
    claim_read(WORD_SIZE);
    claim_read(WORD_SIZE);
    claim_write(32'd1, WORD_SIZE);
    claim_write(32'd0, WORD_SIZE);
    claim_write(32'd33, WORD_SIZE);
    claim_write(32'hFFFF_FFFF, WORD_SIZE);
    claim_read(4'd0);
    claim_read(4'd8);
    claim_write(32'd32, 4'd15);
    send_word(OP_READ, make_item(ENABLE_OFFSET, WORD_SIZE, '0, '0, 1'b0));
    send_word(OP_WRITE, make_item(ENABLE_OFFSET, WORD_SIZE, 32'd32, '0, 1'b0));
    send_word(OP_READ, make_item('1, WORD_SIZE, '1, '1, 1'b1));
    send_word(OP_READ, make_item('0, WORD_SIZE, '0, '0, 1'b0));
    send_word(OP_RESERVED, make_item(CLAIM_OFFSET, WORD_SIZE, 32'd1, 6'd1, 1'b1));
    claim_read(WORD_SIZE);
    claim_write(32'd32, WORD_SIZE);
    line_event(6'd32, 1'b0);
    claim_write(32'd1, WORD_SIZE);

    // Random: mostly line events, claims and completions, plus noise
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      calm = (n >= 200 && n < 330);
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        op = OP_LINE;
        it = make_item(OFFSET_W'($urandom), SIZE_W'($urandom), $urandom,
                       ($urandom_range(0, 1) != 0) ? SRC_W'($urandom_range(1, 8))
                                                   : SRC_W'($urandom_range(1, 32)),
                       $urandom_range(0, 99) < 60);
      end else if (pick < 60) begin
        op = OP_READ;
        it = make_item(CLAIM_OFFSET, WORD_SIZE, $urandom, SRC_W'($urandom), 1'($urandom));
      end else if (pick < 80) begin
        op = OP_WRITE;
        it = make_item(CLAIM_OFFSET, WORD_SIZE,
                       ($urandom_range(0, 1) != 0) ? $urandom_range(1, 8)
                                                   : $urandom_range(0, 33),
                       SRC_W'($urandom), 1'($urandom));
      end else if (pick < 88) begin
        // claim access with a random size, at the claim offset or a neighboring one
        op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
        it = make_item(($urandom_range(0, 1) != 0) ? CLAIM_OFFSET : ENABLE_OFFSET,
                       SIZE_W'($urandom_range(0, 15)), $urandom_range(1, 32),
                       SRC_W'($urandom), 1'($urandom));
      end else begin
        op = OPCODE_W'($urandom_range(0, 3));
        it = make_item(OFFSET_W'($urandom), SIZE_W'($urandom), $urandom,
                       SRC_W'($urandom), 1'($urandom));
      end
      send_word(op, it);
    end
    calm = 0;
    s_axis_tvalid <= 1'b0;

    drain_cycles = 0;
    while (outstanding != 0 && drain_cycles < 2000) begin
      @(negedge clk_i);
      drain_cycles++;
    end
    repeat (8) @(negedge clk_i);
    end_of_run <= 1'b1;
    @(negedge clk_i);

    $display("Covered %0d input words (directed and random, idle and stall gaps),",
             words_sent);
    $display("%0d result words checked, %0d claims granted.",
             results_checked, claims_granted);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Run timed out");
    $display("Regression FAIL");
    $finish;
  end

endmodule
